// ----- sv/atsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsc_pkg
// Shared types and constants of the acknowledged transport session control.
// ----------------------------------------------------------------------------
package atsc_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int NUM_TX       = 2;
  localparam int NUM_SESSIONS = 2;

  // channel index width inside the block
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [7:0] PCI_CONNECT    = 8'h70;
  localparam logic [7:0] PCI_DISCONNECT = 8'h72;
  localparam logic [7:0] PCI_ACK        = 8'h74;

  // configuration register indexes
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RETRY_DELAY = 2'd1;
  localparam logic [1:0] REG_MAX_TRIALS  = 2'd2;
  localparam logic [1:0] REG_DISC_ALLOW  = 2'd3;

  typedef enum logic [3:0] {
    F_TICK     = 4'd0,
    F_SEND     = 4'd1,
    F_CONNECT  = 4'd2,
    F_DISCONN  = 4'd3,
    F_SES_SEND = 4'd4,
    F_PCI      = 4'd5,
    F_MSG_RX   = 4'd6,
    F_LINK_CON = 4'd7,
    F_START    = 4'd8,
    F_STOP     = 4'd9
  } func_t;

  typedef enum logic [3:0] {
    K_SEND     = 4'd0,
    K_SEND_CS  = 4'd1,
    K_SEND_DS  = 4'd2,
    K_SEND_ACK = 4'd3,
    K_T_CON    = 4'd4,
    K_CONN_CON = 4'd5,
    K_DISC_CON = 4'd6,
    K_S_CON    = 4'd7,
    K_CONN_IND = 4'd8,
    K_DISC_IND = 4'd9,
    K_S_IND    = 4'd10,
    K_T_IND    = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    M_NONE      = 3'd0,
    M_IDLE      = 3'd1,
    M_WAITACK   = 3'd2,
    M_EMIT      = 3'd3,
    M_RECV      = 3'd4,
    M_WAITRETRY = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    S_NONE          = 3'd0,
    S_CLOSED        = 3'd1,
    S_OPEN          = 3'd2,
    S_TRANS         = 3'd3,
    S_CONNECTING    = 3'd4,
    S_DISCONNECTING = 3'd5
  } sess_t;

  // classified request handed from front to back
  typedef struct packed {
    func_t           func;
    logic [CH_W-1:0] ch;
    logic [7:0]      pci;
    logic            link_ok;
  } cmd_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [15:0] ack_timeout;
    logic [15:0] retry_delay;
    logic [7:0]  max_trials;
    logic        disc_allowed;
  } cfg_t;

endpackage

// ----- sv/atsc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsc_front
// Request intake: unpacks the stream word, drops requests with an unknown
// function or an out-of-range channel, and forwards the rest to the queue.
// ----------------------------------------------------------------------------
module atsc_front import atsc_pkg::*; (
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // channel[2:0], first_byte[10:3], link_ok[11]
  input  logic [3:0]  s_tuser,   // func[3:0]
  output logic        q_push,
  input  logic        q_ready,
  output cmd_t        q_cmd
);

  logic [2:0] ch_in;
  logic       func_known;
  logic       ch_known;
  logic       no_channel;

  assign ch_in = s_tdata[2:0];

  // classification
  assign func_known = (s_tuser <= F_STOP);
  assign no_channel = (s_tuser == F_TICK) || (s_tuser == F_START) || (s_tuser == F_STOP);
  assign ch_known   = ({1'b0, ch_in} < 4'(NUM_CHANNELS));

  assign s_tready = q_ready;
  assign q_push   = s_tvalid && q_ready && func_known && (no_channel || ch_known);

  always_comb begin
    q_cmd         = '0;
    q_cmd.func    = func_t'(s_tuser);
    q_cmd.ch      = ch_in[CH_W-1:0];
    q_cmd.pci     = s_tdata[10:3];
    q_cmd.link_ok = s_tdata[11];
  end

endmodule

// ----- sv/atsc_cmd_q.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsc_cmd_q
// Two-entry request queue between the intake and the execution engine.
// ----------------------------------------------------------------------------
module atsc_cmd_q import atsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = mem[rptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/atsc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsc_back
// Execution engine: holds channel and session state, runs one request at a
// time, walks the transmit channels on a tick and emits results in order.
// ----------------------------------------------------------------------------
module atsc_back import atsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  output logic       q_pop,
  input  cmd_t       q_cmd,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // out_channel[2:0], success[3], zero[7:4]
  output logic [3:0] m_tuser,    // kind[3:0]
  output logic       m_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TRETRY,
    ST_TACK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       v;
    kind_t      kind;
    logic [2:0] ch;
    logic       ok;
  } res_t;

  typedef struct packed {
    logic  v;
    kind_t kind;
    sess_t st;
  } sconf_t;

  state_t          state;
  cmd_t            cmd;
  logic [CH_W-1:0] walk;
  logic            active;

  mode_t       mode  [NUM_CHANNELS];
  logic [15:0] ackc  [NUM_CHANNELS];
  logic [15:0] retc  [NUM_CHANNELS];
  logic [7:0]  trial [NUM_CHANNELS];
  logic [7:0]  spci  [NUM_CHANNELS];
  sess_t       sess  [NUM_CHANNELS];

  res_t hold;
  res_t res;
  logic out_free;
  logic compute;
  logic go;
  logic layer_cmd;

  logic [2:0] out_ch_q;
  logic       hold_ok_q;
  kind_t      out_kind_q;
  logic       out_last_q;

  logic [CH_W-1:0] sel;
  logic            sel_tx;
  logic            sel_ses;
  mode_t           n_mode;
  logic [15:0]     n_ack;
  logic [15:0]     n_ret;
  logic [7:0]      n_trial;
  logic [7:0]      n_pci;
  sess_t           n_sess;
  sconf_t          sc;

  // kind of a data frame send, from the session phase
  function automatic kind_t send_kind(sess_t s, logic ses, logic dis);
    kind_t k;
    k = K_SEND;
    if (ses && s == S_CONNECTING) begin
      k = K_SEND_CS;
    end else if (ses && s == S_DISCONNECTING && dis) begin
      k = K_SEND_DS;
    end
    return k;
  endfunction

  // upper-layer confirm and session transition
  function automatic sconf_t sconf(sess_t s, logic ses, logic ok, logic dis);
    sconf_t r;
    r.v    = 1'b0;
    r.kind = K_T_CON;
    r.st   = s;
    if (!ses) begin
      r.v = 1'b1;
    end else if (s == S_CONNECTING) begin
      r.v    = 1'b1;
      r.kind = K_CONN_CON;
      r.st   = ok ? S_OPEN : S_CLOSED;
    end else if (s == S_DISCONNECTING && dis) begin
      r.v    = 1'b1;
      r.kind = K_DISC_CON;
      r.st   = ok ? S_CLOSED : S_OPEN;
    end else if (s == S_TRANS) begin
      r.v    = 1'b1;
      r.kind = K_S_CON;
      r.st   = ok ? S_OPEN : S_CLOSED;
    end
    return r;
  endfunction

  assign sel     = (state == ST_EXEC) ? cmd.ch : walk;
  assign sel_tx  = ({1'b0, sel} < (CH_W+1)'(NUM_TX));
  assign sel_ses = ({1'b0, sel} < (CH_W+1)'(NUM_SESSIONS));

  // result and next state of the selected channel
  always_comb begin
    res     = '0;
    res.ch  = 3'(sel);
    n_mode  = mode[sel];
    n_ack   = ackc[sel];
    n_ret   = retc[sel];
    n_trial = trial[sel];
    n_pci   = spci[sel];
    n_sess  = sess[sel];
    sc      = sconf(sess[sel], sel_ses, 1'b0, cfg.disc_allowed);
    case (state)
      ST_TRETRY: begin
        if (retc[sel] != 16'd0) begin
          n_ret = retc[sel] - 16'd1;
          if (retc[sel] == 16'd1) begin
            n_trial  = trial[sel] + 8'd1;
            n_mode   = M_EMIT;
            res.v    = 1'b1;
            res.kind = send_kind(sess[sel], sel_ses, cfg.disc_allowed);
          end
        end
      end
      ST_TACK: begin
        if (ackc[sel] != 16'd0) begin
          n_ack = ackc[sel] - 16'd1;
          if (ackc[sel] == 16'd1) begin
            if (trial[sel] < cfg.max_trials) begin
              n_ret  = cfg.retry_delay;
              n_mode = M_WAITRETRY;
            end else begin
              res.v    = sc.v;
              res.kind = sc.kind;
              n_sess   = sc.st;
              n_mode   = M_IDLE;
            end
          end
        end
      end
      ST_EXEC: begin
        case (cmd.func)
          F_SEND: begin
            if (sel_tx && active) begin
              n_ack = '0; n_ret = '0; n_trial = '0;
              n_mode   = M_EMIT;
              res.v    = 1'b1;
              res.kind = send_kind(sess[sel], sel_ses, cfg.disc_allowed);
            end
          end
          F_CONNECT: begin
            if (sel_ses && sel_tx && active) begin
              n_ack = '0; n_ret = '0; n_trial = '0;
              n_sess   = S_CONNECTING;
              n_mode   = M_EMIT;
              res.v    = 1'b1;
              res.kind = K_SEND_CS;
            end
          end
          F_DISCONN: begin
            if (sel_ses && (sess[sel] == S_CONNECTING || sess[sel] == S_TRANS ||
                            sess[sel] == S_OPEN)) begin
              n_ack = '0; n_ret = '0; n_trial = '0;
              n_mode = M_IDLE;
              if (cfg.disc_allowed) begin
                n_sess = S_DISCONNECTING;
                if (sel_tx && active) begin
                  n_mode   = M_EMIT;
                  res.v    = 1'b1;
                  res.kind = K_SEND_DS;
                end
              end
            end
          end
          F_SES_SEND: begin
            if (sel_ses) begin
              if (sess[sel] == S_OPEN || sess[sel] == S_TRANS) begin
                n_sess = S_TRANS;
                if (sel_tx && active) begin
                  n_ack = '0; n_ret = '0; n_trial = '0;
                  n_mode   = M_EMIT;
                  res.v    = 1'b1;
                  res.kind = K_SEND;
                end
              end else begin
                res.v    = 1'b1;
                res.kind = K_T_CON;
              end
            end
          end
          F_PCI: begin
            if (active) begin
              n_pci = cmd.pci;
              if (cmd.pci == PCI_ACK) begin
                if (sel_tx && mode[sel] == M_WAITACK) begin
                  sc       = sconf(sess[sel], sel_ses, 1'b1, cfg.disc_allowed);
                  n_ack    = '0;
                  n_mode   = M_IDLE;
                  res.v    = sc.v;
                  res.kind = sc.kind;
                  res.ok   = 1'b1;
                  n_sess   = sc.st;
                end else if (sel_tx && mode[sel] == M_EMIT) begin
                  if (trial[sel] < cfg.max_trials) begin
                    n_ret = cfg.retry_delay;
                  end else begin
                    n_ret    = '0;
                    res.v    = sc.v;
                    res.kind = sc.kind;
                    n_sess   = sc.st;
                  end
                end
              end else if (cmd.pci == PCI_CONNECT || cmd.pci == PCI_DISCONNECT) begin
                if (!sel_tx) begin
                  n_mode   = M_RECV;
                  res.v    = 1'b1;
                  res.kind = K_SEND_ACK;
                end
              end
            end
          end
          F_MSG_RX: begin
            if (active && !sel_tx && (!sel_ses || sess[sel] == S_OPEN)) begin
              n_pci    = cmd.pci;
              n_mode   = M_RECV;
              res.v    = 1'b1;
              res.kind = K_SEND_ACK;
            end
          end
          F_LINK_CON: begin
            if (active && mode[sel] == M_EMIT) begin
              if (cmd.link_ok) begin
                n_ack  = cfg.ack_timeout;
                n_mode = M_WAITACK;
              end else if (trial[sel] < cfg.max_trials) begin
                n_ret = cfg.retry_delay;
              end else begin
                n_ret    = '0;
                res.v    = sc.v;
                res.kind = sc.kind;
                n_sess   = sc.st;
              end
            end else if (active && mode[sel] == M_RECV) begin
              n_mode = M_IDLE;
              if (cmd.link_ok) begin
                if (!sel_ses) begin
                  res.v    = 1'b1;
                  res.kind = K_T_IND;
                end else begin
                  n_pci = '0;
                  if (sess[sel] == S_CLOSED) begin
                    if (spci[sel] == PCI_CONNECT) begin
                      n_sess   = S_OPEN;
                      res.v    = 1'b1;
                      res.kind = K_CONN_IND;
                    end else if (spci[sel] == PCI_DISCONNECT) begin
                      res.v    = 1'b1;
                      res.kind = K_DISC_IND;
                    end
                  end else if (sess[sel] == S_OPEN) begin
                    res.v = 1'b1;
                    if (spci[sel] == PCI_DISCONNECT) begin
                      n_sess   = S_CLOSED;
                      res.kind = K_DISC_IND;
                    end else if (spci[sel] == PCI_CONNECT) begin
                      res.kind = K_CONN_IND;
                    end else begin
                      res.kind = K_S_IND;
                    end
                  end
                end
              end
            end
          end
          default: begin
            res.v = 1'b0;
          end
        endcase
      end
      default: begin
        res.v = 1'b0;
      end
    endcase
  end

  // stall when a held result must move out and the output is still full
  assign out_free  = !m_tvalid || m_tready;
  assign compute   = (state == ST_EXEC) || (state == ST_TRETRY) || (state == ST_TACK);
  assign go        = compute ? !(res.v && hold.v && !out_free)
                             : (state != ST_DONE) || !hold.v || out_free;
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign layer_cmd = (state == ST_EXEC) && (cmd.func == F_START || cmd.func == F_STOP);

  assign m_tdata = {4'b0000, hold_ok_q, out_ch_q};
  assign m_tuser = out_kind_q;
  assign m_tlast = out_last_q;

  // sequencer, state store and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      active   <= 1'b0;
      hold.v   <= 1'b0;
      m_tvalid <= 1'b0;
      walk     <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mode[i]  <= M_NONE;
        ackc[i]  <= '0;
        retc[i]  <= '0;
        trial[i] <= '0;
        spci[i]  <= '0;
        sess[i]  <= S_NONE;
      end
    end else begin
      // move the held result to the output
      if (go && hold.v && ((compute && res.v) || state == ST_DONE)) begin
        m_tvalid   <= 1'b1;
        out_kind_q <= hold.kind;
        out_ch_q   <= hold.ch;
        hold_ok_q  <= hold.ok;
        out_last_q <= (state == ST_DONE);
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (go && compute) begin
        if (res.v) begin
          hold <= res;
        end
        if (!layer_cmd) begin
          mode[sel]  <= n_mode;
          ackc[sel]  <= n_ack;
          retc[sel]  <= n_ret;
          trial[sel] <= n_trial;
          spci[sel]  <= n_pci;
          sess[sel]  <= n_sess;
        end
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd  <= q_cmd;
            walk <= '0;
            state <= (q_cmd.func == F_TICK) ? ST_TRETRY : ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go) begin
            state <= ST_DONE;
            if (layer_cmd) begin
              active <= (cmd.func == F_START);
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                mode[i]  <= (cmd.func == F_START) ? M_IDLE : M_NONE;
                ackc[i]  <= '0;
                retc[i]  <= '0;
                trial[i] <= '0;
                if (cmd.func == F_START) begin
                  spci[i] <= '0;
                end
                if (i < NUM_SESSIONS) begin
                  sess[i] <= (cmd.func == F_START) ? S_CLOSED : S_NONE;
                end
              end
            end
          end
        end
        ST_TRETRY: begin
          if (go) begin
            state <= ST_TACK;
          end
        end
        ST_TACK: begin
          if (go) begin
            if (walk == CH_W'(NUM_TX - 1)) begin
              state <= ST_DONE;
            end else begin
              walk  <= walk + 1'b1;
              state <= ST_TRETRY;
            end
          end
        end
        ST_DONE: begin
          if (go) begin
            hold.v <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // nothing is held back between requests
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold.v) else $error("result held while idle");

  // the tick walk stays on transmit channels
  a_walk_tx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRETRY || state == ST_TACK) |-> (walk < CH_W'(NUM_TX)))
    else $error("tick walk left the transmit channels");

  // a stopped layer has no running timers on channel 0
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    !active |-> (ackc[0] == 16'd0 && retc[0] == 16'd0))
    else $error("timer running while layer stopped");

  // a request is only taken when the engine is free
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_EXEC || state == ST_TRETRY))
    else $error("request taken without starting work");

endmodule

// ----- sv/acked_transport_session_ctl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acked_transport_session_ctl
// Per-channel acknowledged transport with sessions: top level.
// ----------------------------------------------------------------------------
// Requests enter on the s_ side into a two-entry queue and are run one at a
// time by the execution engine. A request that is not a tick goes through
// three engine steps (take, execute, close); a tick is taken, then the engine
// visits each transmit channel twice, once for the retry timer and once
// for the ack timer, and closes. At most one result leaves per cycle, and the
// final result of a request carries tlast; a stalled output holds the engine
// while the queue keeps taking requests until it is full. Configuration
// writes take effect at the next clock edge.
module acked_transport_session_ctl import atsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // channel[2:0], first_byte[10:3], link_ok[11]
  input  logic [3:0]  s_tuser,   // func[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_channel[2:0], success[3]
  output logic [3:0]  m_tuser,   // kind[3:0]
  output logic        m_tlast
);

  cfg_t cfg;
  logic f_push;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_timeout  <= 16'd10;
      cfg.retry_delay  <= 16'd5;
      cfg.max_trials   <= 8'd3;
      cfg.disc_allowed <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACK_TIMEOUT: cfg.ack_timeout  <= cfg_wdata;
        REG_RETRY_DELAY: cfg.retry_delay  <= cfg_wdata;
        REG_MAX_TRIALS:  cfg.max_trials   <= cfg_wdata[7:0];
        REG_DISC_ALLOW:  cfg.disc_allowed <= cfg_wdata[0];
        default:         cfg.disc_allowed <= cfg.disc_allowed;
      endcase
    end
  end

  atsc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_push   (f_push),
    .q_ready  (f_ready),
    .q_cmd    (f_cmd)
  );

  atsc_cmd_q u_q (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  atsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the acknowledged transport session control.
// A directed table covers layer start/stop, every request type, the protocol
// bytes, ignored channels and unknown codes. Random phases under several
// register settings follow. A local model of channel modes, timers and
// session states predicts every result, which is compared in order.
// ----------------------------------------------------------------------------
module tb_top import atsc_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic [3:0] func;
    logic [2:0] ch;
    logic [7:0] pci;
    logic       ok;
  } request_t;

  typedef struct {
    kind_t      kind;
    logic [2:0] ch;
    logic       ok;
    logic       last;
  } result_t;

  // directed row: request plus an optional typed single result
  typedef struct {
    request_t req;
    logic     typed;
    kind_t    kind;
    logic     ok;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [3:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  acked_transport_session_ctl uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // model state and registers
  logic [15:0] ack_timeout, retry_delay;
  logic [7:0]  trials_max;
  logic        disc_allowed;
  logic        layer_on;
  mode_t       chan_mode [NUM_CHANNELS];
  logic [15:0] ack_cnt [NUM_CHANNELS];
  logic [15:0] retry_cnt [NUM_CHANNELS];
  logic [7:0]  tries [NUM_CHANNELS];
  logic [7:0]  pci_seen [NUM_CHANNELS];
  sess_t       sess [NUM_SESSIONS + 1];

  result_t batch[$];
  result_t pending_results[$];
  int      errors;
  int      idle_cycles;
  logic    fast_phase;

  function automatic void put(kind_t k, int ch, logic ok);
    result_t r;
    if (batch.size() < 16) begin
      r.kind = k;
      r.ch   = ch[2:0];
      r.ok   = ok;
      r.last = 1'b0;
      batch.push_back(r);
    end
  endfunction

  function automatic void reset_chan(int ch);
    ack_cnt[ch]   = '0;
    retry_cnt[ch] = '0;
    tries[ch]     = '0;
    chan_mode[ch] = M_IDLE;
  endfunction

  function automatic void frame_out(int ch);
    kind_t k;
    k = K_SEND;
    if (ch < NUM_SESSIONS) begin
      if (sess[ch] == S_CONNECTING) k = K_SEND_CS;
      else if (sess[ch] == S_DISCONNECTING && disc_allowed) k = K_SEND_DS;
    end
    put(k, ch, 1'b0);
  endfunction

  function automatic void confirm_up(int ch, logic ok);
    if (ch < NUM_SESSIONS) begin
      if (sess[ch] == S_CONNECTING) begin
        sess[ch] = ok ? S_OPEN : S_CLOSED;
        put(K_CONN_CON, ch, ok);
      end else if (sess[ch] == S_DISCONNECTING && disc_allowed) begin
        sess[ch] = ok ? S_CLOSED : S_OPEN;
        put(K_DISC_CON, ch, ok);
      end else if (sess[ch] == S_TRANS) begin
        sess[ch] = ok ? S_OPEN : S_CLOSED;
        put(K_S_CON, ch, ok);
      end
    end else begin
      put(K_T_CON, ch, ok);
    end
  endfunction

  function automatic void indicate_up(int ch);
    if (ch < NUM_SESSIONS) begin
      if (sess[ch] == S_CLOSED) begin
        if (pci_seen[ch] == PCI_CONNECT) begin
          sess[ch] = S_OPEN;
          put(K_CONN_IND, ch, 1'b0);
        end else if (pci_seen[ch] == PCI_DISCONNECT) begin
          put(K_DISC_IND, ch, 1'b0);
        end
      end else if (sess[ch] == S_OPEN) begin
        if (pci_seen[ch] == PCI_DISCONNECT) begin
          sess[ch] = S_CLOSED;
          put(K_DISC_IND, ch, 1'b0);
        end else if (pci_seen[ch] == PCI_CONNECT) begin
          put(K_CONN_IND, ch, 1'b0);
        end else begin
          put(K_S_IND, ch, 1'b0);
        end
      end
      pci_seen[ch] = '0;
    end else begin
      put(K_T_IND, ch, 1'b0);
    end
  endfunction

  function automatic void start_tx(int ch);
    if (ch < NUM_TX && layer_on) begin
      reset_chan(ch);
      chan_mode[ch] = M_EMIT;
      frame_out(ch);
    end
  endfunction

  function automatic void link_result(int ch, logic ok);
    if (chan_mode[ch] == M_EMIT) begin
      if (ok) begin
        ack_cnt[ch]   = ack_timeout;
        chan_mode[ch] = M_WAITACK;
      end else if (tries[ch] < trials_max) begin
        retry_cnt[ch] = retry_delay;
      end else begin
        retry_cnt[ch] = '0;
        confirm_up(ch, 1'b0);
      end
    end else if (chan_mode[ch] == M_RECV) begin
      chan_mode[ch] = M_IDLE;
      if (ok) indicate_up(ch);
    end
  endfunction

  // timers of the transmit channels, retry before ack
  function automatic void tick_timers();
    for (int ch = 0; ch < NUM_TX; ch++) begin
      if (retry_cnt[ch] != 0) begin
        retry_cnt[ch]--;
        if (retry_cnt[ch] == 0) begin
          tries[ch]++;
          chan_mode[ch] = M_EMIT;
          frame_out(ch);
        end
      end
      if (ack_cnt[ch] != 0) begin
        ack_cnt[ch]--;
        if (ack_cnt[ch] == 0) begin
          if (tries[ch] < trials_max) begin
            retry_cnt[ch] = retry_delay;
            chan_mode[ch] = M_WAITRETRY;
          end else begin
            confirm_up(ch, 1'b0);
            chan_mode[ch] = M_IDLE;
          end
        end
      end
    end
  endfunction

  // results of one request, left in batch with last marked
  function automatic void predict_results(request_t q);
    int ch;
    batch.delete();
    ch = q.ch;
    if (q.func == F_TICK) begin
      tick_timers();
    end else if (q.func == F_START) begin
      layer_on = 1'b1;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        reset_chan(i);
        pci_seen[i] = '0;
      end
      for (int i = 0; i < NUM_SESSIONS; i++) sess[i] = S_CLOSED;
    end else if (q.func == F_STOP) begin
      layer_on = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        reset_chan(i);
        chan_mode[i] = M_NONE;
      end
      for (int i = 0; i < NUM_SESSIONS; i++) sess[i] = S_NONE;
    end else if (ch < NUM_CHANNELS) begin
      case (q.func)
        F_SEND: start_tx(ch);
        F_CONNECT: begin
          if (ch < NUM_SESSIONS && ch < NUM_TX && layer_on) begin
            reset_chan(ch);
            sess[ch] = S_CONNECTING;
            start_tx(ch);
          end
        end
        F_DISCONN: begin
          if (ch < NUM_SESSIONS &&
              (sess[ch] == S_CONNECTING || sess[ch] == S_TRANS || sess[ch] == S_OPEN)) begin
            reset_chan(ch);
            if (disc_allowed) begin
              sess[ch] = S_DISCONNECTING;
              start_tx(ch);
            end
          end
        end
        F_SES_SEND: begin
          if (ch < NUM_SESSIONS) begin
            if (sess[ch] == S_OPEN || sess[ch] == S_TRANS) begin
              sess[ch] = S_TRANS;
              start_tx(ch);
            end else begin
              put(K_T_CON, ch, 1'b0);
            end
          end
        end
        F_PCI: begin
          if (layer_on) begin
            pci_seen[ch] = q.pci;
            if (q.pci == PCI_ACK) begin
              if (ch < NUM_TX) begin
                if (chan_mode[ch] == M_WAITACK) begin
                  ack_cnt[ch]   = '0;
                  chan_mode[ch] = M_IDLE;
                  confirm_up(ch, 1'b1);
                end else if (chan_mode[ch] == M_EMIT) begin
                  link_result(ch, 1'b0);
                end
              end
            end else if (q.pci == PCI_CONNECT || q.pci == PCI_DISCONNECT) begin
              if (ch >= NUM_TX) begin
                chan_mode[ch] = M_RECV;
                put(K_SEND_ACK, ch, 1'b0);
              end
            end
          end
        end
        F_MSG_RX: begin
          if (layer_on && ch >= NUM_TX && (ch >= NUM_SESSIONS || sess[ch] == S_OPEN)) begin
            pci_seen[ch]  = q.pci;
            chan_mode[ch] = M_RECV;
            put(K_SEND_ACK, ch, 1'b0);
          end
        end
        F_LINK_CON: if (layer_on) link_result(ch, q.ok);
        default: ;
      endcase
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
  endfunction

  function automatic void flag_error(string what, result_t exp_r, result_t act_r);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected kind %0d ch %0d ok %0d last %0d,%s%0d%s%0d%s%0d%s%0d",
               what, exp_r.kind, exp_r.ch, exp_r.ok, exp_r.last,
               " got kind ", act_r.kind, " ch ", act_r.ch, " ok ", act_r.ok,
               " last ", act_r.last);
  endfunction

  // drive one request and wait for its acceptance
  task automatic send_request(request_t q);
    int gap;
    int pick;
    pick = $urandom_range(0, 19);
    if (fast_phase || pick < 12) gap = 0;
    else if (pick < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= q.func;
    s_tdata  <= {4'b0, q.ok, q.pci, q.ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_results(q);
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endtask

  // hold off until every result is in and the engine has settled
  task automatic wait_quiet();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] ack, logic [15:0] retry, logic [7:0] trials,
                            logic disc);
    wait_quiet();
    cfg_we <= 1'b1; cfg_index <= REG_ACK_TIMEOUT; cfg_wdata <= ack;
    @(posedge clk);
    cfg_index <= REG_RETRY_DELAY; cfg_wdata <= retry;
    @(posedge clk);
    cfg_index <= REG_MAX_TRIALS; cfg_wdata <= {8'b0, trials};
    @(posedge clk);
    cfg_index <= REG_DISC_ALLOW; cfg_wdata <= {15'b0, disc};
    @(posedge clk);
    cfg_we <= 1'b0;
    ack_timeout  = ack;
    retry_delay  = retry;
    trials_max   = trials;
    disc_allowed = disc;
  endtask

  function automatic request_t random_request();
    request_t q;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) q.func = F_TICK;
    else if (r < 44) q.func = F_SEND;
    else if (r < 51) q.func = F_CONNECT;
    else if (r < 56) q.func = F_DISCONN;
    else if (r < 64) q.func = F_SES_SEND;
    else if (r < 75) q.func = F_PCI;
    else if (r < 82) q.func = F_MSG_RX;
    else if (r < 94) q.func = F_LINK_CON;
    else if (r < 96) q.func = F_START;
    else if (r < 97) q.func = F_STOP;
    else q.func = 4'($urandom_range(10, 15));
    q.ch = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
    r = $urandom_range(0, 9);
    if (r < 3) q.pci = PCI_ACK;
    else if (r < 5) q.pci = PCI_CONNECT;
    else if (r < 6) q.pci = PCI_DISCONNECT;
    else q.pci = 8'($urandom_range(0, 255));
    q.ok = ($urandom_range(0, 3) != 0);
    return q;
  endfunction

  function automatic row_t row(func_t f, int ch, logic [7:0] pci, logic ok,
                               logic typed = 1'b0, kind_t k = K_SEND, logic kok = 1'b0);
    row_t r;
    r.req.func = f;
    r.req.ch   = ch[2:0];
    r.req.pci  = pci;
    r.req.ok   = ok;
    r.typed    = typed;
    r.kind     = k;
    r.ok       = kok;
    return r;
  endfunction

  // output side: random stalls and in-order comparison
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        result_t act_r;
        act_r.kind = kind_t'(m_tuser);
        act_r.ch   = m_tdata[2:0];
        act_r.ok   = m_tdata[3];
        act_r.last = m_tlast;
        if (pending_results.size() == 0) begin
          flag_error("unexpected result", act_r, act_r);
        end else begin
          result_t exp_r;
          exp_r = pending_results.pop_front();
          if (exp_r.kind != act_r.kind || exp_r.ch != act_r.ch ||
              exp_r.ok != act_r.ok || exp_r.last != act_r.last)
            flag_error("result field", exp_r, act_r);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (!fast_phase && $urandom_range(0, 9) < 3) begin
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  row_t directed[$];

  initial begin
    request_t q;
    row_t r;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    fast_phase = 1'b0;
    errors     = 0;
    ack_timeout = 16'd10; retry_delay = 16'd5; trials_max = 8'd3; disc_allowed = 1'b1;
    layer_on = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      chan_mode[i] = M_NONE; ack_cnt[i] = '0; retry_cnt[i] = '0;
      tries[i] = '0; pci_seen[i] = '0;
    end
    for (int i = 0; i <= NUM_SESSIONS; i++) sess[i] = S_NONE;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under the reset settings
    directed = '{
      row(F_SEND, 0, 8'h00, 1'b1),
      row(F_LINK_CON, 2, 8'hFF, 1'b1),
      row(func_t'(4'd12), 0, 8'h00, 1'b0),
      row(F_START, 5, 8'hFF, 1'b0),
      row(F_SEND, 1, 8'h00, 1'b0, 1'b1, K_SEND, 1'b0),
      row(F_SEND, 7, 8'h00, 1'b1),
      row(F_CONNECT, 0, 8'h00, 1'b0, 1'b1, K_SEND_CS, 1'b0),
      row(F_LINK_CON, 0, 8'h00, 1'b1),
      row(F_PCI, 0, PCI_ACK, 1'b0, 1'b1, K_CONN_CON, 1'b1),
      row(F_SES_SEND, 0, 8'h00, 1'b0, 1'b1, K_SEND, 1'b0),
      row(F_PCI, 0, PCI_ACK, 1'b0),
      row(F_SES_SEND, 1, 8'h00, 1'b0, 1'b1, K_T_CON, 1'b0),
      row(F_SES_SEND, 3, 8'h00, 1'b0),
      row(F_MSG_RX, 2, 8'hAB, 1'b0, 1'b1, K_SEND_ACK, 1'b0),
      row(F_LINK_CON, 2, 8'h00, 1'b1, 1'b1, K_T_IND, 1'b0),
      row(F_PCI, 3, PCI_CONNECT, 1'b0, 1'b1, K_SEND_ACK, 1'b0),
      row(F_LINK_CON, 3, 8'h00, 1'b0),
      row(F_PCI, 3, PCI_DISCONNECT, 1'b0, 1'b1, K_SEND_ACK, 1'b0),
      row(F_TICK, 0, 8'hFF, 1'b1),
      row(F_LINK_CON, 1, 8'h00, 1'b0),
      row(F_DISCONN, 0, 8'h00, 1'b0),
      row(F_CONNECT, 3, 8'h00, 1'b0),
      row(func_t'(4'd15), 7, 8'hFF, 1'b1),
      row(F_STOP, 0, 8'h00, 1'b0),
      row(F_PCI, 2, PCI_CONNECT, 1'b0)
    };
    foreach (directed[i]) begin
      r = directed[i];
      send_request(r.req);
      if (r.typed && (batch.size() != 1 || batch[0].kind != r.kind || batch[0].ok != r.ok)) begin
        result_t want;
        want.kind = r.kind; want.ch = r.req.ch; want.ok = r.ok; want.last = 1'b1;
        flag_error("directed row", want, (batch.size() > 0) ? batch[0] : want);
      end
    end

    // random phases under short timers, extremes and the floor values
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_regs(16'd2, 16'd1, 8'd2, 1'b1);
        1: write_regs(16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        2: write_regs(16'd1, 16'd1, 8'd0, 1'b1);
        default: write_regs(16'd3, 16'd2, 8'd1, 1'b0);
      endcase
      fast_phase = (phase == 2);
      q.func = F_START; q.ch = '0; q.pci = '0; q.ok = 1'b0;
      send_request(q);
      for (int n = 0; n < 88; n++) begin
        send_request(random_request());
        if (n == 40 && phase == 0) wait_quiet();
      end
    end

    wait_quiet();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
